[src/ssl_pkg.sv]
// ============================================================================
// ssl_pkg - shared types and constants for the servo slew limiter
// Field widths, register indexes, opcodes, controller state and the
// command/status bundles between the controller and the datapath.
// ============================================================================
package ssl_pkg;

    localparam int CHANNELS_DEF = 16;
    localparam int CHANNELS_MAX = 16;

    localparam int OPCODE_W = 1;
    localparam int ID_W     = 8;
    localparam int ANGLE_W  = 11;
    localparam int TIME_W   = 32;
    localparam int CH_OUT_W = 4;
    localparam int PULSE_W  = 12;
    localparam int DELAY_W  = 16;
    localparam int ANG_W    = 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_MIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_MAX  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_DELAY = 2'd2;

    localparam logic [PULSE_W-1:0] PULSE_MIN_RST  = 12'd150;
    localparam logic [PULSE_W-1:0] PULSE_MAX_RST  = 12'd600;
    localparam logic [DELAY_W-1:0] STEP_DELAY_RST = 16'd10;

    // opcodes
    localparam logic [OPCODE_W-1:0] OP_TICK = 1'b0;
    localparam logic [OPCODE_W-1:0] OP_SET  = 1'b1;

    // result status codes
    localparam logic ST_OK     = 1'b0;
    localparam logic ST_BAD_ID = 1'b1;

    localparam logic [ANG_W-1:0] ANGLE_MAX = 8'd180;

    // divide by 180: q = (x * RECIP_K) >> RECIP_SHIFT, exact for x < 2^20
    localparam int RECIP_SHIFT = 28;
    localparam int RECIP_W     = 21;
    localparam logic [RECIP_W-1:0] RECIP_K = 21'd1491309;
    localparam int MAG_W       = 20;
    localparam int PROD_W      = 22;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DECODE = 6'b000010,
        S_SCAN   = 6'b000100,
        S_CALC   = 6'b001000,
        S_PUSH   = 6'b010000,
        S_FLUSH  = 6'b100000
    } t_state;

    typedef struct packed {
        logic load;        // latch a new input item
        logic set_wr;      // write target, first drive if channel idle
        logic step_wr;     // one-degree step of the scanned channel
        logic calc_start;  // launch a pulse computation
        logic idx_inc;     // advance the scan index
        logic push;        // new result into pending slot
        logic push_err;    // the pushed result is a bad-id error
        logic flush;       // pending slot to output, marked last
    } t_ctrl_cmd;

    typedef struct packed {
        logic is_set;
        logic id_bad;
        logic ch_valid;
        logic step_ok;
        logic idx_last;
        logic pend_valid;
        logic out_free;
        logic calc_done;
    } t_dp_status;

endpackage

[src/ssl_pulse.sv]
// ============================================================================
// ssl_pulse - angle to PWM count
// pulse = min + angle*(max-min)/180, truncated toward zero. Four register
// stages: operands, product, scaled magnitude, final sum.
// ============================================================================
module ssl_pulse (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [ssl_pkg::ANG_W-1:0]    i_angle,
    input  logic [ssl_pkg::PULSE_W-1:0]  i_min,
    input  logic [ssl_pkg::PULSE_W-1:0]  i_max,
    output logic                         o_done,
    output logic [ssl_pkg::PULSE_W-1:0]  o_pulse
);
    import ssl_pkg::*;

    logic [3:0]                  r_v;
    logic [ANG_W-1:0]            r_a;
    logic signed [PULSE_W:0]     r_diff;
    logic signed [PROD_W-1:0]    r_prod;
    logic [PULSE_W-1:0]          r_q;
    logic                        r_neg;
    logic [PULSE_W-1:0]          r_pulse;

    logic [MAG_W-1:0]                    w_mag;
    logic [MAG_W+RECIP_W-1:0]            w_scaled;

    always_comb begin
        w_mag    = r_prod[PROD_W-1] ? MAG_W'(-r_prod) : MAG_W'(r_prod);
        w_scaled = (MAG_W+RECIP_W)'(w_mag) * (MAG_W+RECIP_W)'(RECIP_K);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[2:0], i_start};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a    <= i_angle;
            r_diff <= $signed({1'b0, i_max}) - $signed({1'b0, i_min});
        end
        r_prod  <= PROD_W'($signed({1'b0, r_a})) * PROD_W'(r_diff);
        r_q     <= w_scaled[RECIP_SHIFT +: PULSE_W];
        r_neg   <= r_prod[PROD_W-1];
        r_pulse <= r_neg ? (i_min - r_q) : (i_min + r_q);
    end

    assign o_done  = r_v[3];
    assign o_pulse = r_pulse;

endmodule

[src/ssl_datapath.sv]
// ============================================================================
// ssl_datapath - channel state, scan index and result registers
// Holds per-channel angle/target/time, evaluates the step test for the
// indexed channel and stages results through a pending slot and an output
// register so the last flag can be set once the scan ends.
// ============================================================================
module ssl_datapath #(
    parameter int CHANNELS = ssl_pkg::CHANNELS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ssl_pkg::t_ctrl_cmd            i_cmd,
    output ssl_pkg::t_dp_status           o_status,
    input  logic [ssl_pkg::OPCODE_W-1:0]  i_opcode,
    input  logic [ssl_pkg::ID_W-1:0]      i_servo_id,
    input  logic signed [ssl_pkg::ANGLE_W-1:0] i_angle,
    input  logic [ssl_pkg::TIME_W-1:0]    i_now_ms,
    input  logic [ssl_pkg::PULSE_W-1:0]   i_pulse_min,
    input  logic [ssl_pkg::PULSE_W-1:0]   i_pulse_max,
    input  logic [ssl_pkg::DELAY_W-1:0]   i_step_delay,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output logic [ssl_pkg::CH_OUT_W-1:0]  o_channel,
    output logic [ssl_pkg::PULSE_W-1:0]   o_pulse,
    output logic                          o_st,
    output logic                          o_last
);
    import ssl_pkg::*;

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // latched item
    logic                 r_is_set;
    logic                 r_id_bad;
    logic [IDX_W-1:0]     r_idx;
    logic [ANG_W-1:0]     r_clamp;
    logic [TIME_W-1:0]    r_now;

    // channel state
    logic [CHANNELS-1:0]  r_valid;
    logic [ANG_W-1:0]     r_cur  [CHANNELS];
    logic [ANG_W-1:0]     r_tgt  [CHANNELS];
    logic [TIME_W-1:0]    r_time [CHANNELS];

    // pending slot and output register
    logic                 r_pend_valid;
    logic [CH_OUT_W-1:0]  r_pend_ch;
    logic [PULSE_W-1:0]   r_pend_pulse;
    logic                 r_pend_st;
    logic                 r_out_valid;
    logic [CH_OUT_W-1:0]  r_out_ch;
    logic [PULSE_W-1:0]   r_out_pulse;
    logic                 r_out_st;
    logic                 r_out_last;

    logic [ANG_W-1:0]     w_cur;
    logic [ANG_W-1:0]     w_tgt;
    logic [ANG_W-1:0]     w_next;
    logic [TIME_W-1:0]    w_age;
    logic                 w_out_free;
    logic                 w_calc_done;
    logic [PULSE_W-1:0]   w_calc_pulse;
    logic [ANG_W-1:0]     w_calc_angle;
    logic [ANG_W-1:0]     w_clamp_in;

    always_comb begin
        if (i_angle < 0) begin
            w_clamp_in = '0;
        end else if (i_angle > $signed({3'b000, ANGLE_MAX})) begin
            w_clamp_in = ANGLE_MAX;
        end else begin
            w_clamp_in = i_angle[ANG_W-1:0];
        end
    end

    always_comb begin
        w_cur        = r_cur[r_idx];
        w_tgt        = r_tgt[r_idx];
        w_next       = (w_tgt > w_cur) ? (w_cur + 1'b1) : (w_cur - 1'b1);
        w_age        = r_now - r_time[r_idx];
        w_out_free   = !r_out_valid || !i_out_stall;
        w_calc_angle = r_is_set ? r_clamp : w_next;
    end

    always_comb begin
        o_status.is_set     = r_is_set;
        o_status.id_bad     = r_id_bad;
        o_status.ch_valid   = r_valid[r_idx];
        o_status.step_ok    = r_valid[r_idx] && (w_cur != w_tgt) &&
                              (w_age >= TIME_W'(i_step_delay));
        o_status.idx_last   = (r_idx == IDX_W'(CHANNELS - 1));
        o_status.pend_valid = r_pend_valid;
        o_status.out_free   = w_out_free;
        o_status.calc_done  = w_calc_done;
    end

    ssl_pulse u_pulse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.calc_start),
        .i_angle (w_calc_angle),
        .i_min   (i_pulse_min),
        .i_max   (i_pulse_max),
        .o_done  (w_calc_done),
        .o_pulse (w_calc_pulse)
    );

    // item latch and scan index
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_is_set <= (i_opcode == OP_SET);
            r_id_bad <= (i_servo_id == '0) || (i_servo_id > ID_W'(CHANNELS));
            r_idx    <= (i_opcode == OP_SET) ? IDX_W'(i_servo_id - 1'b1) : '0;
            r_clamp  <= w_clamp_in;
            r_now    <= i_now_ms;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    // channel state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.set_wr && !r_valid[r_idx]) begin
            r_valid[r_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.set_wr) begin
            r_tgt[r_idx] <= r_clamp;
            if (!r_valid[r_idx]) begin
                r_cur[r_idx]  <= r_clamp;
                r_time[r_idx] <= r_now;
            end
        end else if (i_cmd.step_wr) begin
            r_cur[r_idx]  <= w_next;
            r_time[r_idx] <= r_now;
        end
    end

    // result staging
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.push) begin
                r_pend_valid <= 1'b1;
            end else if (i_cmd.flush) begin
                r_pend_valid <= 1'b0;
            end
            if ((i_cmd.push && r_pend_valid) || i_cmd.flush) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((i_cmd.push && r_pend_valid) || i_cmd.flush) begin
            r_out_ch    <= r_pend_ch;
            r_out_pulse <= r_pend_pulse;
            r_out_st    <= r_pend_st;
            r_out_last  <= i_cmd.flush;
        end
        if (i_cmd.push) begin
            if (i_cmd.push_err) begin
                r_pend_ch    <= '0;
                r_pend_pulse <= '0;
                r_pend_st    <= ST_BAD_ID;
            end else begin
                r_pend_ch    <= CH_OUT_W'(r_idx);
                r_pend_pulse <= w_calc_pulse;
                r_pend_st    <= ST_OK;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_channel   = r_out_ch;
    assign o_pulse     = r_out_pulse;
    assign o_st        = r_out_st;
    assign o_last      = r_out_last;

endmodule

[src/ssl_ctrl.sv]
// ============================================================================
// ssl_ctrl - sequencing state machine
// Accepts one item at a time, walks the channels on a tick, waits on the
// pulse unit and drains the pending result with the last flag.
// ============================================================================
module ssl_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  ssl_pkg::t_dp_status  i_status,
    output ssl_pkg::t_ctrl_cmd   o_cmd
);
    import ssl_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                if (!i_status.is_set) begin
                    n_state = S_SCAN;
                end else if (i_status.id_bad) begin
                    o_cmd.push     = 1'b1;
                    o_cmd.push_err = 1'b1;
                    n_state        = S_FLUSH;
                end else begin
                    o_cmd.set_wr = 1'b1;
                    if (!i_status.ch_valid) begin
                        o_cmd.calc_start = 1'b1;
                        n_state          = S_CALC;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_SCAN: begin
                if (i_status.step_ok) begin
                    o_cmd.step_wr    = 1'b1;
                    o_cmd.calc_start = 1'b1;
                    n_state          = S_CALC;
                end else if (i_status.idx_last) begin
                    n_state = S_FLUSH;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_CALC: begin
                if (i_status.calc_done) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (!i_status.pend_valid || i_status.out_free) begin
                    o_cmd.push = 1'b1;
                    if (i_status.is_set || i_status.idx_last) begin
                        n_state = S_FLUSH;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        n_state       = S_SCAN;
                    end
                end
            end
            S_FLUSH: begin
                if (!i_status.pend_valid) begin
                    n_state = S_IDLE;
                end else if (i_status.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

[src/servo_slew_limiter.sv]
// ============================================================================
// servo_slew_limiter - multi-channel servo slew rate limiter
// Set-target items load a clamped angle per channel; tick items step every
// due channel one degree toward its target and report its new PWM count.
// ============================================================================
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+-----------------------------------
//  input    | i_in_valid / o_in_stall      | i_opcode i_servo_id i_angle i_now_ms
//  result   | o_out_valid / i_out_stall    | o_channel o_pulse o_status o_last
//  config   | i_cfg_valid / o_cfg_ready    | i_cfg_index i_cfg_data
//
//  Sequence: a set-target on a driven channel is accepted and decoded; a bad id
//  is also pushed and flushed; a first drive also runs the pulse pipeline. A
//  tick walks one channel per cycle, detouring through the shared pulse unit
//  and a push for each stepping channel, and may wait on a stalled result.
//  Reset (synchronous, active low) clears valid bits, state machine and result
//  valids. A stalled result holds back only the next push or flush.
//
module servo_slew_limiter #(
    parameter int CHANNELS = ssl_pkg::CHANNELS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input items
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [ssl_pkg::OPCODE_W-1:0]       i_opcode,
    input  logic [ssl_pkg::ID_W-1:0]           i_servo_id,
    input  logic signed [ssl_pkg::ANGLE_W-1:0] i_angle,
    input  logic [ssl_pkg::TIME_W-1:0]         i_now_ms,
    // result items
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [ssl_pkg::CH_OUT_W-1:0]       o_channel,
    output logic [ssl_pkg::PULSE_W-1:0]        o_pulse,
    output logic                               o_status,
    output logic                               o_last,
    // configuration writes
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [ssl_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ssl_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import ssl_pkg::*;

    // configuration registers
    logic [PULSE_W-1:0] r_pulse_min;
    logic [PULSE_W-1:0] r_pulse_max;
    logic [DELAY_W-1:0] r_step_delay;

    t_ctrl_cmd  w_cmd;
    t_dp_status w_status;

    // the user must send writes only while idle; the block does not enforce it and takes every write
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_min  <= PULSE_MIN_RST;
            r_pulse_max  <= PULSE_MAX_RST;
            r_step_delay <= STEP_DELAY_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_PULSE_MIN:  r_pulse_min  <= i_cfg_data[PULSE_W-1:0];
                REG_PULSE_MAX:  r_pulse_max  <= i_cfg_data[PULSE_W-1:0];
                REG_STEP_DELAY: r_step_delay <= i_cfg_data[DELAY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // sequencing
    ssl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // channel state, pulse math and result staging
    ssl_datapath #(
        .CHANNELS (CHANNELS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_opcode     (i_opcode),
        .i_servo_id   (i_servo_id),
        .i_angle      (i_angle),
        .i_now_ms     (i_now_ms),
        .i_pulse_min  (r_pulse_min),
        .i_pulse_max  (r_pulse_max),
        .i_step_delay (r_step_delay),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_channel    (o_channel),
        .o_pulse      (o_pulse),
        .o_st         (o_status),
        .o_last       (o_last)
    );

endmodule

[src/ssl_checker.sv]
// ============================================================================
// ssl_checker - port-level checks for the servo slew limiter
// Watches the top-level ports and flags handshake and result-format slips.
// ============================================================================
module ssl_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               o_in_stall,
    input logic                               o_out_valid,
    input logic                               i_out_stall,
    input logic [ssl_pkg::CH_OUT_W-1:0]       o_channel,
    input logic [ssl_pkg::PULSE_W-1:0]        o_pulse,
    input logic                               o_status,
    input logic                               o_last
);
    import ssl_pkg::*;

    // a stalled result stays up
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // an accepted item is worked on before the next one is taken
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second item taken without a busy cycle");

    // a bad-id result is the only result of its item and carries no pulse
    a_err_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_BAD_ID) |->
            o_last && (o_channel == '0) && (o_pulse == '0))
        else $error("malformed bad-id result");

    // a result not marked last is followed by more results of the same item
    a_no_new_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_last |-> o_in_stall)
        else $error("block ready while item results still pending");

endmodule

bind servo_slew_limiter ssl_checker u_ssl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_channel   (o_channel),
    .o_pulse     (o_pulse),
    .o_status    (o_status),
    .o_last      (o_last)
);
